### sv/hwan_pkg.sv
// ----------------------------------------------------------------------------
// hwan_pkg: shared types and constants for the hexagonal wrap-around block
// Coordinate widths, the image step tables and the pipeline payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package hwan_pkg;

  // coordinates and configuration
  localparam int COORD_W     = 24;
  localparam int SITE_W      = 17;
  localparam int OP_W        = 2;
  localparam int IMAGE_COUNT = 8;
  localparam int SEL_W       = $clog2(IMAGE_COUNT);
  localparam int IDX_W       = 4;
  localparam int NCAND       = IMAGE_COUNT + 1;

  localparam logic [SITE_W-1:0] SITE_RESET = SITE_W'(8000);

  // sqrt3 in unsigned Q1.16
  localparam int SQRT3_W = 17;
  localparam logic [SQRT3_W-1:0] SQRT3_Q16 = SQRT3_W'(113512);
  localparam int PROD_W = SITE_W + SQRT3_W;

  // half-step multipliers per image, as magnitude and sign
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] HX_MAG [IMAGE_COUNT] =
    '{4'd7, 4'd6, 4'd1, 4'd8, 4'd7, 4'd1, 4'd8, 4'd15};
  localparam logic [STEP_W-1:0] HY_MAG [IMAGE_COUNT] =
    '{4'd3, 4'd8, 4'd5, 4'd2, 4'd3, 4'd5, 4'd2, 4'd1};
  localparam logic [IMAGE_COUNT-1:0] HX_NEG = 8'b0001_1100;
  localparam logic [IMAGE_COUNT-1:0] HY_NEG = 8'b0111_0000;

  localparam int XM_W  = SITE_W + STEP_W;
  localparam int YM_W  = PROD_W + STEP_W;
  localparam int OFS_W = 21;

  // datapath widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int DEL_W  = COORD_W + 2;
  localparam int ABS_W  = COORD_W + 1;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int DIST_W = SQ_W + 1;

  // table rebuild time after a site distance write
  localparam int RB_W = 2;
  localparam logic [RB_W-1:0] REBUILD_CYC = RB_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_NEAR_BS = 2'd0,
    OP_NEAR_UE = 2'd1,
    OP_SHIFT   = 2'd2
  } op_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OFS_W-1:0]   ofs_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [IDX_W-1:0]          idx_t;

  typedef struct packed {
    ofs_t x;
    ofs_t y;
  } offset_t;

  typedef struct packed {
    dist_t dsq;
    idx_t  idx;
  } cand_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SEL_W-1:0] sel;
    coord_t           mx;
    coord_t           my;
  } ctl_t;

endpackage

`default_nettype wire

### sv/hwan_in_if.sv
// ----------------------------------------------------------------------------
// hwan_in_if: request channel into the wrap-around block
// Valid/ready handshake carrying one position query.
// ----------------------------------------------------------------------------
`default_nettype none

interface hwan_in_if import hwan_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [COORD_W-1:0] ue_x;
  logic signed [COORD_W-1:0] ue_y;
  logic signed [COORD_W-1:0] bs_x;
  logic signed [COORD_W-1:0] bs_y;
  logic [SEL_W-1:0]          image_select;

  modport source (
    output valid, operation, ue_x, ue_y, bs_x, bs_y, image_select,
    input  ready
  );

  modport sink (
    input  valid, operation, ue_x, ue_y, bs_x, bs_y, image_select,
    output ready
  );

endinterface

`default_nettype wire

### sv/hwan_out_if.sv
// ----------------------------------------------------------------------------
// hwan_out_if: result channel out of the wrap-around block
// Valid/ready handshake carrying the chosen position and its image number.
// ----------------------------------------------------------------------------
`default_nettype none

interface hwan_out_if import hwan_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic [IDX_W-1:0]          image_index;
  logic                      saturated;

  modport source (
    output valid, out_x, out_y, image_index, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, image_index, saturated,
    output ready
  );

endinterface

`default_nettype wire

### sv/hex_wrap_around_nearest_image.sv
// ----------------------------------------------------------------------------
// hex_wrap_around_nearest_image: nearest-image wrap-around for 19-site layout
// Picks the nearest of a position and its eight images, or applies one image.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  - valid/ready request: operation, terminal and base positions,
//              image number for the fixed shift.
//   out_chan - valid/ready result: position, image index, saturation flag.
//   cfg_*    - site distance write; the image offset table is rebuilt from it
//              in the product and offset registers, with in_chan.ready held low.
// Throughput is one request per cycle while out_chan and the table rebuild
// do not stall it. A request passes from the accepting edge to out_chan.valid
// through nine register stages: difference, magnitude, square, sum, three
// comparison levels, index select and the add/clamp output register. The
// squaring lanes (nine candidates, x and y) set the depth of one stage.
// Reset clears every stage valid and reloads the site distance of 8000; the
// offset table is rebuilt before the first request is taken.
// A stall on out_chan holds the output register; stages behind it keep
// filling their empty slots, so requests are still taken while bubbles remain.
// Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_wrap_around_nearest_image import hwan_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  hwan_in_if.sink                in_chan,
  hwan_out_if.source             out_chan,
  input  wire logic              cfg_wr_en,
  input  wire logic [SITE_W-1:0] cfg_wr_data
);

  localparam int NSTG = 9;

  // configuration and offset table
  logic [SITE_W-1:0] site_r;
  logic [PROD_W-1:0] prod_r;
  logic [RB_W-1:0]   rb_cnt_r;
  offset_t           ofs_tab_r [IMAGE_COUNT];
  offset_t           ofs_tab_nxt [IMAGE_COUNT];

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;
  logic            in_ok;

  // stage payloads
  ctl_t                     ctl_r [NSTG-1];
  ctl_t                     ctl_nxt;
  logic signed [DIFF_W-1:0] dfx_r, dfy_r, dfx_nxt, dfy_nxt;
  logic [ABS_W-1:0]         ax_r [NCAND];
  logic [ABS_W-1:0]         ay_r [NCAND];
  logic [ABS_W-1:0]         ax_nxt [NCAND];
  logic [ABS_W-1:0]         ay_nxt [NCAND];
  logic [SQ_W-1:0]          sqx_r [NCAND];
  logic [SQ_W-1:0]          sqy_r [NCAND];
  dist_t                    dist_r [NCAND];
  cand_t                    lva_r [5];
  cand_t                    lvb_r [3];
  cand_t                    lvc_r [2];
  idx_t                     idx_r, idx_nxt;
  coord_t                   ox_r, oy_r, ox_nxt, oy_nxt;
  idx_t                     oidx_r;
  logic                     osat_r, osat_nxt;

  // keep the lower index unless the right one is strictly nearer
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.dsq < a.dsq) ? b : a;
  endfunction

  // clamp a widened sum back to the coordinate range
  function automatic coord_t clamp(input logic signed [DIFF_W-1:0] v);
    if (v[DIFF_W-1] != v[DIFF_W-2]) begin
      return v[DIFF_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return v[COORD_W-1:0];
  endfunction

  // hold the site distance; count down the table rebuild
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_r   <= SITE_RESET;
      rb_cnt_r <= REBUILD_CYC;
    end else if (cfg_wr_en) begin
      site_r   <= cfg_wr_data;
      rb_cnt_r <= REBUILD_CYC;
    end else if (rb_cnt_r != '0) begin
      rb_cnt_r <= rb_cnt_r - RB_W'(1);
    end
  end

  // derive offsets: x = hx*D/2, y = hy*D*sqrt3/2, rounded half away from zero
  always_comb begin
    logic [XM_W-1:0] xm;
    logic [XM_W-1:0] xr;
    logic [YM_W-1:0] ym;
    logic [YM_W-1:0] yr;
    for (int n = 0; n < IMAGE_COUNT; n++) begin
      xm = XM_W'(site_r) * XM_W'(HX_MAG[n]);
      xr = (xm + XM_W'(1)) >> 1;
      ym = YM_W'(prod_r) * YM_W'(HY_MAG[n]);
      yr = (ym + (YM_W'(1) << 16)) >> 17;
      ofs_tab_nxt[n].x = HX_NEG[n] ? -OFS_W'(xr) : OFS_W'(xr);
      ofs_tab_nxt[n].y = HY_NEG[n] ? -OFS_W'(yr) : OFS_W'(yr);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(site_r) * PROD_W'(SQRT3_Q16);
    for (int n = 0; n < IMAGE_COUNT; n++) begin
      ofs_tab_r[n] <= ofs_tab_nxt[n];
    end
  end

  // advance each stage when it is empty or the next one advances
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_chan.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ok         = (rb_cnt_r == '0);
  assign in_chan.ready = en[0] && in_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_chan.valid && in_ok;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 0: choose moving and fixed points, take their difference
  always_comb begin
    coord_t fx, fy;
    ctl_nxt.op  = in_chan.operation;
    ctl_nxt.sel = in_chan.image_select;
    unique case (in_chan.operation)
      OP_NEAR_BS: begin
        ctl_nxt.mx = in_chan.bs_x;
        ctl_nxt.my = in_chan.bs_y;
        fx         = in_chan.ue_x;
        fy         = in_chan.ue_y;
      end
      OP_NEAR_UE: begin
        ctl_nxt.mx = in_chan.ue_x;
        ctl_nxt.my = in_chan.ue_y;
        fx         = in_chan.bs_x;
        fy         = in_chan.bs_y;
      end
      default: begin
        ctl_nxt.mx = in_chan.bs_x;
        ctl_nxt.my = in_chan.bs_y;
        fx         = in_chan.bs_x;
        fy         = in_chan.bs_y;
      end
    endcase
    dfx_nxt = DIFF_W'(fx) - DIFF_W'(ctl_nxt.mx);
    dfy_nxt = DIFF_W'(fy) - DIFF_W'(ctl_nxt.my);
  end

  // stage 1: per candidate distance components, as magnitudes
  always_comb begin
    offset_t                 off;
    logic signed [DEL_W-1:0] ddx, ddy;
    for (int n = 0; n < NCAND; n++) begin
      off = '0;
      if (n != 0) begin
        off = ofs_tab_r[SEL_W'(n - 1)];
      end
      ddx = DEL_W'(dfx_r) - DEL_W'(off.x);
      ddy = DEL_W'(dfy_r) - DEL_W'(off.y);
      ax_nxt[n] = ABS_W'(ddx[DEL_W-1] ? -ddx : ddx);
      ay_nxt[n] = ABS_W'(ddy[DEL_W-1] ? -ddy : ddy);
    end
  end

  // stage 7: final image number per operation
  always_comb begin
    cand_t best;
    best = pick(lvc_r[0], lvc_r[1]);
    unique case (ctl_r[6].op) inside
      OP_NEAR_BS, OP_NEAR_UE: idx_nxt = best.idx;
      OP_SHIFT:               idx_nxt = IDX_W'(ctl_r[6].sel) + IDX_W'(1);
      default:                idx_nxt = '0;
    endcase
  end

  // stage 8: apply the chosen offset and clamp
  always_comb begin
    offset_t                  off;
    logic signed [DIFF_W-1:0] sx, sy;
    off = '0;
    if (idx_r != '0) begin
      off = ofs_tab_r[SEL_W'(idx_r - IDX_W'(1))];
    end
    sx       = DIFF_W'(ctl_r[7].mx) + DIFF_W'(off.x);
    sy       = DIFF_W'(ctl_r[7].my) + DIFF_W'(off.y);
    ox_nxt   = clamp(sx);
    oy_nxt   = clamp(sy);
    osat_nxt = (sx[DIFF_W-1] != sx[DIFF_W-2]) || (sy[DIFF_W-1] != sy[DIFF_W-2]);
  end

  // pipeline payload registers
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ctl_r[0] <= ctl_nxt;
      dfx_r    <= dfx_nxt;
      dfy_r    <= dfy_nxt;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (en[k]) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
    if (en[1]) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
    end
    if (en[2]) begin
      for (int n = 0; n < NCAND; n++) begin
        sqx_r[n] <= SQ_W'(ax_r[n]) * SQ_W'(ax_r[n]);
        sqy_r[n] <= SQ_W'(ay_r[n]) * SQ_W'(ay_r[n]);
      end
    end
    if (en[3]) begin
      for (int n = 0; n < NCAND; n++) begin
        dist_r[n] <= DIST_W'(sqx_r[n]) + DIST_W'(sqy_r[n]);
      end
    end
    if (en[4]) begin
      for (int i = 0; i < 4; i++) begin
        lva_r[i] <= pick('{dsq: dist_r[2*i], idx: IDX_W'(2*i)},
                         '{dsq: dist_r[2*i+1], idx: IDX_W'(2*i+1)});
      end
      lva_r[4] <= '{dsq: dist_r[NCAND-1], idx: IDX_W'(NCAND-1)};
    end
    if (en[5]) begin
      lvb_r[0] <= pick(lva_r[0], lva_r[1]);
      lvb_r[1] <= pick(lva_r[2], lva_r[3]);
      lvb_r[2] <= lva_r[4];
    end
    if (en[6]) begin
      lvc_r[0] <= pick(lvb_r[0], lvb_r[1]);
      lvc_r[1] <= lvb_r[2];
    end
    if (en[7]) begin
      idx_r <= idx_nxt;
    end
    if (en[8]) begin
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oidx_r <= idx_r;
      osat_r <= osat_nxt;
    end
  end

  // drive the result channel from the output register
  assign out_chan.valid       = vld_r[NSTG-1];
  assign out_chan.out_x       = ox_r;
  assign out_chan.out_y       = oy_r;
  assign out_chan.image_index = oidx_r;
  assign out_chan.saturated   = osat_r;

endmodule

`default_nettype wire

### test/nearest_image_checker.sv
// ----------------------------------------------------------------------------
// nearest_image_checker: result predictor and scoreboard for the wrap-around
// Watches the request and result channels and the site distance port, keeps
// its own image offset table, predicts the chosen position for every accepted
// request and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module nearest_image_checker import hwan_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  hwan_in_if                in_mon,
  hwan_out_if               out_mon,
  input  logic              cfg_wr_en,
  input  logic [SITE_W-1:0] cfg_wr_data,
  output int                pending,
  output int                fail_count,
  output int                image_hits,
  output int                clamp_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  // half-site steps of each image, x in D/2 and y in sqrt3*D/2
  localparam int HALF_X [IMAGE_COUNT] = '{7, 6, -1, -8, -7, 1, 8, 15};
  localparam int HALF_Y [IMAGE_COUNT] = '{3, 8, 5, 2, -3, -5, -2, 1};
  localparam longint ROOT3_Q16 = 113512;
  localparam longint COORD_HI  = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_LO  = -COORD_HI - 1;

  typedef struct packed {
    coord_t x;
    coord_t y;
    idx_t   idx;
    logic   sat;
  } place_t;

  longint shift_x [IMAGE_COUNT];
  longint shift_y [IMAGE_COUNT];
  place_t expected_places [$];

  // round num / 2^sh to nearest, halves away from zero
  function automatic longint round_half_away(longint num, int sh);
    longint mag;
    longint r;
    mag = (num < 0) ? -num : num;
    r = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
    return (num < 0) ? -r : r;
  endfunction

  // rebuild the whole offset table from one site distance
  function automatic void load_site_distance(logic [SITE_W-1:0] d);
    for (int n = 0; n < IMAGE_COUNT; n++) begin
      shift_x[n] = round_half_away(HALF_X[n] * longint'(d), 1);
      shift_y[n] = round_half_away(HALF_Y[n] * longint'(d) * ROOT3_Q16, 17);
    end
  endfunction

  function automatic longint dist_sq(longint dx, longint dy);
    return dx * dx + dy * dy;
  endfunction

  function automatic longint clamp_coord(longint v, inout logic sat);
    if (v > COORD_HI) begin
      sat = 1'b1;
      return COORD_HI;
    end
    if (v < COORD_LO) begin
      sat = 1'b1;
      return COORD_LO;
    end
    return v;
  endfunction

  // nearest of the moving point and its eight images, or one fixed image
  function automatic place_t predict_place(logic [OP_W-1:0] op, coord_t ux, coord_t uy,
                                           coord_t bx, coord_t by,
                                           logic [SEL_W-1:0] sel);
    longint mx, my, fx, fy, cx, cy, px, py, best, dd;
    place_t p;
    logic   sat;
    px    = bx;
    py    = by;
    p.idx = '0;
    sat   = 1'b0;
    case (op) inside
      OP_NEAR_BS, OP_NEAR_UE: begin
        if (op == OP_NEAR_BS) begin
          mx = bx; my = by; fx = ux; fy = uy;
        end else begin
          mx = ux; my = uy; fx = bx; fy = by;
        end
        best = dist_sq(fx - mx, fy - my);
        px = mx;
        py = my;
        // strict compare: unshifted and lower images keep ties
        for (int n = 0; n < IMAGE_COUNT; n++) begin
          cx = mx + shift_x[n];
          cy = my + shift_y[n];
          dd = dist_sq(fx - cx, fy - cy);
          if (dd < best) begin
            best  = dd;
            px    = cx;
            py    = cy;
            p.idx = idx_t'(n + 1);
          end
        end
      end
      OP_SHIFT: begin
        px    = longint'(bx) + shift_x[sel];
        py    = longint'(by) + shift_y[sel];
        p.idx = idx_t'(sel) + idx_t'(1);
      end
      default: ;
    endcase
    p.x   = coord_t'(clamp_coord(px, sat));
    p.y   = coord_t'(clamp_coord(py, sat));
    p.sat = sat;
    return p;
  endfunction

  initial begin
    pending    = 0;
    fail_count = 0;
    image_hits = 0;
    clamp_hits = 0;
    load_site_distance(SITE_RESET);
  end

  // track configuration, queue predictions, compare results in order
  always @(posedge clk) begin
    place_t got;
    place_t want;
    if (!rst_n) begin
      load_site_distance(SITE_RESET);
      expected_places.delete();
    end else begin
      if (cfg_wr_en)
        load_site_distance(cfg_wr_data);
      if (in_mon.valid && in_mon.ready)
        expected_places.push_back(predict_place(in_mon.operation, in_mon.ue_x, in_mon.ue_y,
                                                in_mon.bs_x, in_mon.bs_y,
                                                in_mon.image_select));
      if (out_mon.valid && out_mon.ready) begin
        got.x   = out_mon.out_x;
        got.y   = out_mon.out_y;
        got.idx = out_mon.image_index;
        got.sat = out_mon.saturated;
        if (expected_places.size() == 0) begin
          $error("result with no request outstanding: x %0d y %0d index %0d",
                 got.x, got.y, got.idx);
          fail_count++;
        end else begin
          want = expected_places.pop_front();
          if (got.x !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, got.x);
            fail_count++;
          end
          if (got.y !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, got.y);
            fail_count++;
          end
          if (got.idx !== want.idx) begin
            $error("image_index: expected %0d, got %0d", want.idx, got.idx);
            fail_count++;
          end
          if (got.sat !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, got.sat);
            fail_count++;
          end
          if (want.idx != '0)
            image_hits++;
          if (want.sat)
            clamp_hits++;
        end
      end
    end
    pending = expected_places.size();
  end

endmodule

### test/tb_hex_wrap_around_nearest_image.sv
// ----------------------------------------------------------------------------
// tb_hex_wrap_around_nearest_image: testbench top for the wrap-around block
// Drives position requests and site distance writes, stalls both channels in
// random bursts, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_hex_wrap_around_nearest_image import hwan_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int     SITE_MAX     = (1 << SITE_W) - 1;
  localparam coord_t C_MAX        = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam coord_t C_MIN        = {1'b1, {(COORD_W - 1){1'b0}}};
  localparam int     PHASES       = 6;
  localparam int     PHASE_ITEMS  = 122;
  localparam int     HOLD_CYCLES  = 60;
  localparam int     DRAIN_CYCLES = 20;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [SITE_W-1:0] cfg_wr_data = SITE_RESET;
  logic              quiet       = 1'b0;
  logic              hold_req    = 1'b0;
  int                site_now    = int'(SITE_RESET);
  int                request_count = 0;
  int                setting_count = 0;
  int                pending, fail_count, image_hits, clamp_hits;

  hwan_in_if  in_if ();
  hwan_out_if out_if ();

  hex_wrap_around_nearest_image u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  nearest_image_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pending     (pending),
    .fail_count  (fail_count),
    .image_hits  (image_hits),
    .clamp_hits  (clamp_hits)
  );

  always #5 clk = ~clk;

  // offer one request, hold it until taken, then drop valid
  task automatic send_query(logic [OP_W-1:0] op, coord_t ux, coord_t uy, coord_t bx,
                            coord_t by, logic [SEL_W-1:0] sel);
    if (!quiet && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 14)) @(negedge clk);
    in_if.operation    = op;
    in_if.ue_x         = ux;
    in_if.ue_y         = uy;
    in_if.bs_x         = bx;
    in_if.bs_y         = by;
    in_if.image_select = sel;
    in_if.valid        = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    in_if.valid = 1'b0;
    request_count++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  // write the site distance only once the pipeline is empty
  task automatic set_site_distance(int d);
    drain();
    cfg_wr_data = d[SITE_W-1:0];
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    site_now    = d;
    setting_count++;
  endtask

  function automatic coord_t clip(longint v);
    if (v > longint'(C_MAX))
      return C_MAX;
    if (v < longint'(C_MIN))
      return C_MIN;
    return coord_t'(v);
  endfunction

  function automatic logic [SEL_W-1:0] any_sel();
    return SEL_W'($urandom_range(0, 7));
  endfunction

  // mostly anywhere, sometimes within a few images of either edge
  function automatic coord_t pick_coord(int d);
    case ($urandom_range(0, 9))
      0:       return clip(longint'(C_MAX) - longint'($urandom_range(0, 2 * d + 16)));
      1:       return clip(longint'(C_MIN) + longint'($urandom_range(0, 2 * d + 16)));
      default: return coord_t'($urandom());
    endcase
  endfunction

  // mostly terminal/site pairs a few sites apart, the rest shifts and noise
  task automatic random_query();
    coord_t ux, uy, bx, by;
    longint span;
    int     kind;
    kind = $urandom_range(0, 99);
    span = longint'(site_now) * 4 + 64;
    bx   = pick_coord(site_now);
    by   = pick_coord(site_now);
    if (kind < 65) begin
      ux = clip(longint'(bx) + longint'($urandom_range(0, int'(2 * span))) - span);
      uy = clip(longint'(by) + longint'($urandom_range(0, int'(2 * span))) - span);
      send_query(kind[0] ? OP_NEAR_UE : OP_NEAR_BS, ux, uy, bx, by, any_sel());
    end else if (kind < 80) begin
      send_query(OP_SHIFT, coord_t'($urandom()), coord_t'($urandom()), bx, by,
                 any_sel());
    end else if (kind < 95) begin
      send_query(kind[0] ? OP_NEAR_UE : OP_NEAR_BS, coord_t'($urandom()),
                 coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
                 any_sel());
    end else begin
      send_query(OP_UNUSED, coord_t'($urandom()), coord_t'($urandom()), bx, by,
                 any_sel());
    end
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_if.ready = 1'b1;
        hold_req     = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_if.ready = 1'b1;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.operation    = '0;
    in_if.ue_x         = '0;
    in_if.ue_y         = '0;
    in_if.bs_x         = '0;
    in_if.bs_y         = '0;
    in_if.image_select = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset distance: origin, far corners, exact image hits, every fixed shift
    send_query(OP_NEAR_BS, '0, '0, '0, '0, '0);
    send_query(OP_NEAR_UE, C_MIN, C_MIN, C_MAX, C_MAX, '0);
    send_query(OP_NEAR_BS, C_MAX, C_MAX, C_MIN, C_MIN, SEL_W'(7));
    send_query(OP_NEAR_BS, coord_t'(28000), coord_t'(20785), '0, '0, '0);
    send_query(OP_NEAR_UE, coord_t'(-28000), coord_t'(-20785), '0, '0, '0);
    for (int s = 0; s < IMAGE_COUNT; s++)
      send_query(OP_SHIFT, '0, '0, s[0] ? C_MAX : C_MIN, s[1] ? C_MAX : C_MIN, SEL_W'(s));
    send_query(OP_UNUSED, C_MAX, C_MIN, coord_t'(-5), coord_t'(5), SEL_W'(7));

    // tiny distance: terminal on the bisector with the first image keeps the
    // site; terminal equidistant from two images takes the lower one
    set_site_distance(16);
    send_query(OP_NEAR_BS, coord_t'(1028), coord_t'(-1979), coord_t'(1000),
               coord_t'(-2000), '0);
    send_query(OP_NEAR_BS, coord_t'(1060), coord_t'(-1993), coord_t'(1000),
               coord_t'(-2000), '0);

    // zero distance: every image ties with the original
    set_site_distance(0);
    send_query(OP_NEAR_UE, coord_t'(123), coord_t'(-456), coord_t'(-789),
               coord_t'(1011), '0);
    send_query(OP_SHIFT, '0, '0, C_MAX, C_MIN, SEL_W'(7));

    // largest distance: clamping on both edges
    set_site_distance(SITE_MAX);
    send_query(OP_SHIFT, '0, '0, C_MAX, C_MAX, SEL_W'(7));
    send_query(OP_SHIFT, '0, '0, C_MIN, C_MIN, SEL_W'(3));
    send_query(OP_NEAR_BS, C_MAX, C_MAX, C_MIN, C_MIN, '0);
    send_query(OP_NEAR_UE, C_MIN, C_MIN, C_MAX, C_MAX, '0);

    // random phases, each under its own site distance
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_site_distance(int'(SITE_RESET));
        1:       set_site_distance($urandom_range(1, 2000));
        2:       set_site_distance(SITE_MAX);
        3:       set_site_distance($urandom_range(0, SITE_MAX));
        4:       set_site_distance(1);
        default: set_site_distance($urandom_range(2000, 20000));
      endcase
      if (ph == 1)
        hold_req = 1'b1;
      if (ph == PHASES - 1)
        quiet = 1'b1;
      repeat (PHASE_ITEMS) random_query();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d requests under %0d site distances, %0d results moved to an image,",
             request_count, setting_count, image_hits);
    $display("summary: %0d clamped, one %0d-cycle result hold-off, drained before each write",
             clamp_hits, HOLD_CYCLES);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
